// File: hw/rtl/servo_keyframe_sequencer_defines.svh
// Assertion macros for the servo keyframe sequencer checker
`ifndef SERVO_KEYFRAME_SEQUENCER_DEFINES_SVH
`define SERVO_KEYFRAME_SEQUENCER_DEFINES_SVH

// Clocked assertion, muted while reset is asserted
`define SKSEQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that also holds during reset
`define SKSEQ_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: hw/rtl/skseq_pkg.sv
// Types, constants and gait ROM contents for the servo keyframe sequencer
`timescale 1ns / 1ps

package skseq_pkg;

  localparam int unsigned NumGaits  = 7;
  localparam int unsigned MaxFrames = 4;
  localparam int unsigned CfgIdxW   = 1;

  localparam logic [15:0] PwmPeriodRst    = 16'd627;
  localparam logic [15:0] TicksPerUnitRst = 16'd312;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgPwmPeriod    = 1'b0,
    CfgTicksPerUnit = 1'b1
  } cfg_idx_e;

  // Gait codes
  typedef enum logic [2:0] {
    GaitStop     = 3'd0,
    GaitFwd      = 3'd1,
    GaitFwdLeft  = 3'd2,
    GaitFwdRight = 3'd3,
    GaitBack     = 3'd4,
    GaitLeft     = 3'd5,
    GaitRight    = 3'd6
  } gait_e;

  // Command byte codes
  localparam logic [7:0] CmdStop     = 8'h73; // 's'
  localparam logic [7:0] CmdFwd      = 8'h66; // 'f'
  localparam logic [7:0] CmdFwdLeft  = 8'h31; // '1'
  localparam logic [7:0] CmdFwdRight = 8'h32; // '2'
  localparam logic [7:0] CmdBack     = 8'h62; // 'b'
  localparam logic [7:0] CmdLeft     = 8'h6c; // 'l'
  localparam logic [7:0] CmdRight    = 8'h72; // 'r'

  typedef struct packed {
    logic       command;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic       pin_center;
    logic       pin_right;
    logic       pin_left;
    logic       outputs_active;
    logic       echo_valid;
    logic [7:0] echo_byte;
    logic [2:0] gait_index;
    logic [1:0] frame_number;
  } out_item_t;

  // One keyframe: width[0] center, width[1] right, width[2] left
  typedef struct packed {
    logic [2:0][7:0] width;
    logic [7:0]      delay;
  } frame_t;

  // Item travelling from the sequencer stage to the pulse stage
  typedef struct packed {
    logic       cmd;
    logic [7:0] rx_byte;
    logic       bnd;
    logic [2:0] gait;
    logic [1:0] pos;
  } stage_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] gait;
  } decode_t;

  function automatic decode_t decode_cmd(input logic [7:0] b);
    decode_t d;
    d.hit  = 1'b1;
    d.gait = GaitStop;
    unique case (b)
      CmdStop:     d.gait = GaitStop;
      CmdFwd:      d.gait = GaitFwd;
      CmdFwdLeft:  d.gait = GaitFwdLeft;
      CmdFwdRight: d.gait = GaitFwdRight;
      CmdBack:     d.gait = GaitBack;
      CmdLeft:     d.gait = GaitLeft;
      CmdRight:    d.gait = GaitRight;
      default:     d.hit  = 1'b0;
    endcase
    if ({29'd0, d.gait} >= NumGaits) d.hit = 1'b0;
    return d;
  endfunction

  // Frames per gait
  function automatic logic [2:0] gait_len(input logic [2:0] g);
    logic [2:0] len;
    unique case (g)
      GaitStop: len = 3'd1;
      default:  len = 3'd4;
    endcase
    return len;
  endfunction

  function automatic frame_t fr(input logic [7:0] c, input logic [7:0] r,
                                input logic [7:0] l, input logic [7:0] d);
    frame_t f;
    f.width[0] = c;
    f.width[1] = r;
    f.width[2] = l;
    f.delay    = d;
    return f;
  endfunction

  // Gait ROM contents
  function automatic frame_t gait_frame(input logic [2:0] g, input logic [1:0] p);
    frame_t f;
    f = fr(8'd38, 8'd40, 8'd42, 8'd20);
    unique case (g)
      GaitFwd, GaitFwdLeft, GaitFwdRight: begin
        unique case (p)
          2'd0: f = fr(8'd33, 8'd50, 8'd51, 8'd5);
          2'd1: f = fr(8'd33, 8'd30, 8'd33, 8'd10);
          2'd2: f = fr(8'd43, 8'd30, 8'd33, 8'd5);
          2'd3: f = fr(8'd43, 8'd50, 8'd51, 8'd10);
        endcase
      end
      GaitBack: begin
        unique case (p)
          2'd0: f = fr(8'd33, 8'd30, 8'd33, 8'd5);
          2'd1: f = fr(8'd33, 8'd50, 8'd51, 8'd10);
          2'd2: f = fr(8'd43, 8'd50, 8'd51, 8'd5);
          2'd3: f = fr(8'd43, 8'd30, 8'd33, 8'd10);
        endcase
      end
      GaitLeft: begin
        unique case (p)
          2'd0: f = fr(8'd35, 8'd30, 8'd42, 8'd10);
          2'd1: f = fr(8'd35, 8'd20, 8'd52, 8'd15);
          2'd2: f = fr(8'd45, 8'd20, 8'd52, 8'd10);
          2'd3: f = fr(8'd45, 8'd30, 8'd42, 8'd15);
        endcase
      end
      GaitRight: begin
        unique case (p)
          2'd0: f = fr(8'd35, 8'd20, 8'd52, 8'd10);
          2'd1: f = fr(8'd35, 8'd30, 8'd42, 8'd15);
          2'd2: f = fr(8'd45, 8'd30, 8'd42, 8'd10);
          2'd3: f = fr(8'd45, 8'd20, 8'd52, 8'd15);
        endcase
      end
      default: f = fr(8'd38, 8'd40, 8'd42, 8'd20);
    endcase
    return f;
  endfunction

endpackage

// File: hw/rtl/skseq_seq.sv
// Keyframe sequencer stage: timing, pending command, gait ROM read
`timescale 1ns / 1ps

module skseq_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [15:0]         tpdu_i,
  input  logic                acc_i,
  input  skseq_pkg::in_item_t item_i,
  input  logic                b_move_i,
  output logic                b_valid_o,
  output skseq_pkg::stage_t   stage_o,
  output skseq_pkg::frame_t   frame_o
);

  logic               load_q;
  logic [2:0]         gait_q;
  logic [1:0]         pos_q;
  logic [15:0]        ut_q;
  logic [7:0]         units_q;
  logic               ul_rom_q;
  logic               pend_vld_q;
  logic [7:0]         pend_byte_q;
  skseq_pkg::frame_t  rom_q;
  logic               b_valid_q;
  skseq_pkg::stage_t  b_q;

  logic [7:0]         ul_eff;
  logic [7:0]         ul_dec;
  logic [15:0]        ut_inc;
  logic               unit_done;
  logic               bnd;
  logic [2:0]         nxt;
  logic [1:0]         pos_a;
  logic [2:0]         gait_n;
  logic [1:0]         pos_n;
  skseq_pkg::decode_t dec;

  // Delay count right after a load comes straight from the ROM read data
  assign ul_eff    = ul_rom_q ? rom_q.delay : units_q;
  assign ul_dec    = (ul_eff != 8'd0) ? ul_eff - 8'd1 : 8'd0;
  assign ut_inc    = ut_q + 16'd1;
  assign unit_done = (ut_inc >= tpdu_i);
  assign bnd       = load_q || (unit_done && (ul_dec == 8'd0));

  // Next gait and frame at a keyframe boundary
  always_comb begin
    nxt   = {1'b0, pos_q} + 3'd1;
    pos_a = pos_q;
    if (!load_q) begin
      pos_a = (nxt >= skseq_pkg::gait_len(gait_q)) ? 2'd0 : nxt[1:0];
    end
    dec    = skseq_pkg::decode_cmd(pend_byte_q);
    gait_n = gait_q;
    pos_n  = pos_a;
    if (pend_vld_q && dec.hit) begin
      gait_n = dec.gait;
      pos_n  = 2'd0;
    end
    if (({1'b0, pos_n} >= skseq_pkg::gait_len(gait_n)) ||
        ({30'd0, pos_n} >= skseq_pkg::MaxFrames)) begin
      pos_n = 2'd0;
    end
  end

  // Sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_q      <= 1'b1;
      gait_q      <= skseq_pkg::GaitStop;
      pos_q       <= 2'd0;
      ut_q        <= 16'd0;
      units_q     <= 8'd0;
      ul_rom_q    <= 1'b0;
      pend_vld_q  <= 1'b0;
      pend_byte_q <= 8'd0;
    end else if (acc_i) begin
      if (item_i.command) begin
        pend_vld_q  <= 1'b1;
        pend_byte_q <= item_i.rx_byte;
      end else if (bnd) begin
        load_q     <= 1'b0;
        gait_q     <= gait_n;
        pos_q      <= pos_n;
        ut_q       <= 16'd0;
        ul_rom_q   <= 1'b1;
        pend_vld_q <= 1'b0;
      end else begin
        ut_q     <= unit_done ? 16'd0 : ut_inc;
        units_q  <= unit_done ? ul_dec : ul_eff;
        ul_rom_q <= 1'b0;
      end
    end
  end

  // Gait ROM, read once per boundary; holds the frame in effect
  always_ff @(posedge clk_i) begin
    if (acc_i && !item_i.command && bnd) begin
      rom_q <= skseq_pkg::gait_frame(gait_n, pos_n);
    end
  end

  // Stage register toward the pulse stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (acc_i) begin
      b_valid_q <= 1'b1;
    end else if (b_move_i) begin
      b_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      b_q.cmd     <= item_i.command;
      b_q.rx_byte <= item_i.rx_byte;
      b_q.bnd     <= !item_i.command && bnd;
      b_q.gait    <= (!item_i.command && bnd) ? gait_n : gait_q;
      b_q.pos     <= (!item_i.command && bnd) ? pos_n : pos_q;
    end
  end

  assign b_valid_o = b_valid_q;
  assign stage_o   = b_q;
  assign frame_o   = rom_q;

endmodule

// File: hw/rtl/skseq_pwm.sv
// Pulse stage: activity check, PWM counter, pin levels and output register
`timescale 1ns / 1ps

module skseq_pwm (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [15:0]          period_i,
  input  logic                 b_valid_i,
  input  skseq_pkg::stage_t    stage_i,
  input  skseq_pkg::frame_t    frame_i,
  input  logic                 out_stall_i,
  output logic                 b_move_o,
  output logic                 out_valid_o,
  output skseq_pkg::out_item_t out_data_o
);

  logic                 act_q;
  logic [2:0]           pin_q;
  logic [15:0]          cnt_q;
  logic [2:0][7:0]      cw_q;
  logic                 out_valid_q;
  skseq_pkg::out_item_t out_q;

  logic                 act_n;
  logic [2:0]           pin_n;
  logic [15:0]          cnt_n;
  logic [2:0][7:0]      cw_n;
  logic [15:0]          c;
  skseq_pkg::out_item_t res;

  assign b_move_o = b_valid_i && (!out_valid_q || !out_stall_i);

  // Pulse update for a tick beat
  always_comb begin
    act_n = act_q;
    pin_n = pin_q;
    cnt_n = cnt_q;
    cw_n  = cw_q;
    c     = cnt_q;
    if (!stage_i.cmd) begin
      if (stage_i.bnd) begin
        act_n = (frame_i.width != cw_q);
        cw_n  = frame_i.width;
      end
      if (!act_n) begin
        pin_n = 3'b000;
      end else begin
        if (c >= period_i) begin
          c     = 16'd0;
          pin_n = 3'b111;
        end
        for (int k = 0; k < 3; k++) begin
          if (c >= {8'd0, cw_n[k]}) pin_n[k] = 1'b0;
        end
        cnt_n = c + 16'd1;
      end
    end
  end

  always_comb begin
    res.pin_center     = pin_n[0];
    res.pin_right      = pin_n[1];
    res.pin_left       = pin_n[2];
    res.outputs_active = act_n;
    res.echo_valid     = stage_i.cmd;
    res.echo_byte      = stage_i.cmd ? stage_i.rx_byte : 8'd0;
    res.gait_index     = stage_i.gait;
    res.frame_number   = stage_i.pos;
  end

  // Pulse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
      pin_q <= 3'b000;
      cnt_q <= 16'd0;
      cw_q  <= '0;
    end else if (b_move_o) begin
      act_q <= act_n;
      pin_q <= pin_n;
      cnt_q <= cnt_n;
      cw_q  <= cw_n;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (b_move_o) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_move_o) out_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: hw/rtl/servo_keyframe_sequencer.sv
// Top level of the servo keyframe sequencer
//
// Input channel (in_valid_i / in_stall_o / in_data_i): one beat per timer
// tick (command = 0) or per received byte (command = 1). Output channel
// (out_valid_o / out_stall_i / out_data_o): exactly one result beat per
// input beat, in order, carrying pin levels, activity, echo, gait, frame.
// Config channel (cfg_valid_i / cfg_ready_o): cfg_index_i 0 = pwm_period,
// 1 = ticks_per_delay_unit; always ready, write only while idle.
// Throughput: one beat per cycle unless the output stalls. The sequencer
// stage reads the gait ROM on a keyframe boundary; the pulse stage consumes
// that read data with the boundary beat, and the following beat takes its
// delay count from it by forwarding. Beats pass stage, then output register.
// Reset: pwm_period 627, ticks_per_delay_unit 312, stop gait, pins low,
// outputs inactive, first tick loads the current keyframe.
// Output stall: the output register holds its beat; the pulse stage and
// then the input channel stall behind it with no beat lost.
`timescale 1ns / 1ps

module servo_keyframe_sequencer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  skseq_pkg::in_item_t               in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output skseq_pkg::out_item_t              out_data_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [skseq_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [15:0]                       cfg_data_i
);

  logic [15:0]       period_q;
  logic [15:0]       tpdu_q;
  logic              acc;
  logic              b_valid;
  logic              b_move;
  skseq_pkg::stage_t stage;
  skseq_pkg::frame_t frame;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = b_valid && !b_move;
  assign acc         = in_valid_i && !in_stall_o;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= skseq_pkg::PwmPeriodRst;
      tpdu_q   <= skseq_pkg::TicksPerUnitRst;
    end else if (cfg_valid_i) begin
      unique case (skseq_pkg::cfg_idx_e'(cfg_index_i))
        skseq_pkg::CfgPwmPeriod:    period_q <= cfg_data_i;
        skseq_pkg::CfgTicksPerUnit: tpdu_q   <= cfg_data_i;
      endcase
    end
  end

  skseq_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .tpdu_i    (tpdu_q),
    .acc_i     (acc),
    .item_i    (in_data_i),
    .b_move_i  (b_move),
    .b_valid_o (b_valid),
    .stage_o   (stage),
    .frame_o   (frame)
  );

  skseq_pwm u_pwm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .period_i    (period_q),
    .b_valid_i   (b_valid),
    .stage_i     (stage),
    .frame_i     (frame),
    .out_stall_i (out_stall_i),
    .b_move_o    (b_move),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

// File: hw/rtl/skseq_checker.sv
// Port-level checker for the servo keyframe sequencer, with its bind
`timescale 1ns / 1ps
`include "servo_keyframe_sequencer_defines.svh"

module skseq_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input skseq_pkg::out_item_t          out_data_o
);

  // Stalled result beat holds
  `SKSEQ_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o), "stalled result beat changed")

  // No result offered while in reset
  `SKSEQ_ASSERT_RST(a_rst_idle, !rst_ni |-> !out_valid_o, "result offered during reset")

  // Echo byte is zero on tick results
  `SKSEQ_ASSERT(a_echo_zero, out_valid_o && !out_data_o.echo_valid |-> out_data_o.echo_byte == 8'd0, "echo byte set on tick")

  // Pins stay low while outputs are inactive
  `SKSEQ_ASSERT(a_pins_low, out_valid_o && !out_data_o.outputs_active |-> !out_data_o.pin_center && !out_data_o.pin_right && !out_data_o.pin_left, "pin high while inactive")

  // Stop gait has a single keyframe
  `SKSEQ_ASSERT(a_stop_frame, out_valid_o && out_data_o.gait_index == skseq_pkg::GaitStop |-> out_data_o.frame_number == 2'd0, "stop gait past frame 0")

endmodule

bind servo_keyframe_sequencer skseq_checker u_skseq_checker (.*);

// File: tb/servo_keyframe_sequencer_tb.sv
// Self-checking testbench for the servo keyframe sequencer: random ticks and command bytes
`timescale 1ns / 1ps

module servo_keyframe_sequencer_tb;
  import skseq_pkg::*;

  // One keyframe as the predictor holds it
  typedef struct packed {
    logic [7:0] c;
    logic [7:0] r;
    logic [7:0] l;
    logic [7:0] d;
  } key_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  in_item_t            in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_item_t           out_data_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [15:0]         cfg_data_i  = '0;

  servo_keyframe_sequencer DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  in_item_t  tick_cmd_q[$];   // beats waiting to be sent
  out_item_t servo_out_q[$];  // predicted result beats, oldest first

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int bad_beats     = 0;
  int checked_beats = 0;
  int n_cmd_bytes   = 0;
  int n_key_loads   = 0;
  int n_settings    = 0;

  // Predictor state and register copies
  logic [15:0] m_period, m_tpu, m_cnt, m_uticks;
  logic [2:0]  m_pins, m_gait;
  logic [1:0]  m_pos;
  logic [7:0]  m_units, m_pend_byte;
  logic        m_active, m_load, m_pend_ok;
  key_t        m_key;

  // Keyframe ROM: {center, right, left, delay}
  function automatic key_t key_rom(input logic [2:0] g, input logic [1:0] p);
    key_t k;
    k = {8'd38, 8'd40, 8'd42, 8'd20};
    case (g)
      GaitFwd, GaitFwdLeft, GaitFwdRight: begin
        case (p)
          2'd0: k = {8'd33, 8'd50, 8'd51, 8'd5};
          2'd1: k = {8'd33, 8'd30, 8'd33, 8'd10};
          2'd2: k = {8'd43, 8'd30, 8'd33, 8'd5};
          default: k = {8'd43, 8'd50, 8'd51, 8'd10};
        endcase
      end
      GaitBack: begin
        case (p)
          2'd0: k = {8'd33, 8'd30, 8'd33, 8'd5};
          2'd1: k = {8'd33, 8'd50, 8'd51, 8'd10};
          2'd2: k = {8'd43, 8'd50, 8'd51, 8'd5};
          default: k = {8'd43, 8'd30, 8'd33, 8'd10};
        endcase
      end
      GaitLeft: begin
        case (p)
          2'd0: k = {8'd35, 8'd30, 8'd42, 8'd10};
          2'd1: k = {8'd35, 8'd20, 8'd52, 8'd15};
          2'd2: k = {8'd45, 8'd20, 8'd52, 8'd10};
          default: k = {8'd45, 8'd30, 8'd42, 8'd15};
        endcase
      end
      GaitRight: begin
        case (p)
          2'd0: k = {8'd35, 8'd20, 8'd52, 8'd10};
          2'd1: k = {8'd35, 8'd30, 8'd42, 8'd15};
          2'd2: k = {8'd45, 8'd30, 8'd42, 8'd10};
          default: k = {8'd45, 8'd20, 8'd52, 8'd15};
        endcase
      end
      default: k = {8'd38, 8'd40, 8'd42, 8'd20};
    endcase
    return k;
  endfunction

  // {known, gait} for a received byte
  function automatic logic [3:0] gait_for_byte(input logic [7:0] b);
    case (b)
      CmdStop:     return {1'b1, GaitStop};
      CmdFwd:      return {1'b1, GaitFwd};
      CmdFwdLeft:  return {1'b1, GaitFwdLeft};
      CmdFwdRight: return {1'b1, GaitFwdRight};
      CmdBack:     return {1'b1, GaitBack};
      CmdLeft:     return {1'b1, GaitLeft};
      CmdRight:    return {1'b1, GaitRight};
      default:     return 4'b0000;
    endcase
  endfunction

  function automatic logic [7:0] cmd_code(input int k);
    case (k)
      0: return CmdStop;
      1: return CmdFwd;
      2: return CmdFwdLeft;
      3: return CmdFwdRight;
      4: return CmdBack;
      5: return CmdLeft;
      default: return CmdRight;
    endcase
  endfunction

  function automatic string beat_str(input out_item_t b);
    return $sformatf("pins c/r/l=%b%b%b act=%b echo=%b/%02h gait=%0d frame=%0d",
                     b.pin_center, b.pin_right, b.pin_left, b.outputs_active,
                     b.echo_valid, b.echo_byte, b.gait_index, b.frame_number);
  endfunction

  task automatic reset_model();
    m_period = PwmPeriodRst;  m_tpu = TicksPerUnitRst;
    m_cnt = '0;  m_uticks = '0;  m_pins = '0;  m_gait = GaitStop;  m_pos = '0;
    m_units = '0;  m_pend_byte = '0;  m_active = 1'b0;  m_load = 1'b1;
    m_pend_ok = 1'b0;  m_key = '0;
  endtask

  // Keyframe boundary: advance, take a pending command, load the next frame
  task automatic load_keyframe(input bit advance);
    int         len;
    logic [3:0] dec;
    key_t       nk;
    len = (m_gait == GaitStop) ? 1 : 4;
    if (advance) m_pos = (int'(m_pos) + 1 >= len) ? 2'd0 : m_pos + 2'd1;
    if (m_pend_ok) begin
      dec = gait_for_byte(m_pend_byte);
      if (dec[3]) begin
        m_gait = dec[2:0];
        m_pos  = 2'd0;
      end
      m_pend_ok = 1'b0;
    end
    len = (m_gait == GaitStop) ? 1 : 4;
    if (int'(m_pos) >= len) m_pos = 2'd0;
    nk = key_rom(m_gait, m_pos);
    m_active = (nk.c != m_key.c) || (nk.r != m_key.r) || (nk.l != m_key.l);
    m_key    = nk;
    m_units  = nk.d;
    m_uticks = '0;
    m_load   = 1'b0;
    n_key_loads++;
  endtask

  // Expected result for one accepted beat
  task automatic predict_servo_beat(input in_item_t it);
    out_item_t o;
    if (it.command) begin
      m_pend_ok   = 1'b1;
      m_pend_byte = it.rx_byte;
      n_cmd_bytes++;
    end else begin
      // sequencer first
      if (m_load) begin
        load_keyframe(1'b0);
      end else begin
        m_uticks = m_uticks + 16'd1;
        if (m_uticks >= m_tpu) begin
          m_uticks = '0;
          if (m_units != 8'd0) m_units = m_units - 8'd1;
          if (m_units == 8'd0) load_keyframe(1'b1);
        end
      end
      // then the pulse counter
      if (!m_active) begin
        m_pins = 3'b000;
      end else begin
        if (m_cnt >= m_period) begin
          m_cnt  = '0;
          m_pins = 3'b111;
        end
        if (m_cnt >= {8'd0, m_key.c}) m_pins[0] = 1'b0;
        if (m_cnt >= {8'd0, m_key.r}) m_pins[1] = 1'b0;
        if (m_cnt >= {8'd0, m_key.l}) m_pins[2] = 1'b0;
        m_cnt = m_cnt + 16'd1;
      end
    end
    o.pin_center     = m_pins[0];
    o.pin_right      = m_pins[1];
    o.pin_left       = m_pins[2];
    o.outputs_active = m_active;
    o.echo_valid     = it.command;
    o.echo_byte      = it.command ? it.rx_byte : 8'd0;
    o.gait_index     = m_gait;
    o.frame_number   = m_pos;
    servo_out_q.push_back(o);
  endtask

  // Input driver: predicts on each accepted beat, then offers the next one
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) predict_servo_beat(in_data_i);
      if (!in_valid_i || !in_stall_o) begin
        if (tick_cmd_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          in_data_i  <= tick_cmd_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output monitor and stall generator
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (servo_out_q.size() == 0) begin
          bad_beats++;
          if (bad_beats <= 10)
            $display("%0t: unexpected beat: %s", $realtime, beat_str(out_data_o));
        end else begin
          want = servo_out_q.pop_front();
          checked_beats++;
          if (out_data_o.pin_center     !== want.pin_center     ||
              out_data_o.pin_right      !== want.pin_right      ||
              out_data_o.pin_left       !== want.pin_left       ||
              out_data_o.outputs_active !== want.outputs_active ||
              out_data_o.echo_valid     !== want.echo_valid     ||
              out_data_o.echo_byte      !== want.echo_byte      ||
              out_data_o.gait_index     !== want.gait_index     ||
              out_data_o.frame_number   !== want.frame_number) begin
            bad_beats++;
            if (bad_beats <= 10)
              $display("%0t: beat %0d\n  expected %s\n  actual   %s", $realtime,
                       checked_beats, beat_str(want), beat_str(out_data_o));
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CfgPwmPeriod) m_period = val;
    else m_tpu = val;
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (tick_cmd_q.size() != 0 || in_valid_i || servo_out_q.size() != 0);
  endtask

  task automatic push_beat(input logic cmd, input logic [7:0] b);
    in_item_t it;
    it.command = cmd;
    it.rx_byte = b;
    tick_cmd_q.push_back(it);
  endtask

  // Mostly ticks so frames advance, with known commands, junk bytes and bursts
  task automatic add_random_beats(input int n);
    int r;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 80) push_beat(1'b0, 8'($urandom_range(255)));
      else if (r < 90) push_beat(1'b1, cmd_code($urandom_range(6)));
      else if (r < 95) push_beat(1'b1, 8'($urandom_range(255)));
      else begin
        repeat ($urandom_range(3, 2)) begin
          if ($urandom_range(1)) push_beat(1'b1, cmd_code($urandom_range(6)));
          else push_beat(1'b1, 8'($urandom_range(255)));
        end
      end
    end
  endtask

  // Stimulus sequence
  initial begin
    logic [15:0] per, tpu;
    reset_model();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: junk bytes, then a command overwriting them before the first tick
    push_beat(1'b1, 8'h00);
    push_beat(1'b1, 8'hff);
    push_beat(1'b1, CmdFwd);
    push_beat(1'b0, 8'hff);
    push_beat(1'b0, 8'h00);
    wait_drained();
    n_settings++;

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin per = 16'd60;    tpu = 16'd0;     end
        1: begin per = 16'd0;     tpu = 16'd1;     end
        2: begin per = 16'd65535; tpu = 16'd2;     end
        3: begin per = 16'd1;     tpu = 16'd3;     end
        4: begin per = 16'd45;    tpu = 16'd65535; end
        5: begin per = 16'd100;   tpu = 16'd4;     end
        6: begin per = 16'd52;    tpu = 16'd1;     end
        default: begin per = PwmPeriodRst; tpu = TicksPerUnitRst; end
      endcase
      repeat (4) @(posedge clk_i);
      write_reg(CfgPwmPeriod, per);
      write_reg(CfgTicksPerUnit, tpu);
      n_settings++;

      // idle profile: none, sender, receiver, both lightly
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 60; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 60; end
        default: begin send_idle_pct = 7; stall_pct = 7; end
      endcase

      // every remaining command once, each followed by a couple of ticks
      if (ph == 0) begin
        for (int k = 0; k < 7; k++) begin
          if (k == 1) continue;
          push_beat(1'b1, cmd_code(k));
          push_beat(1'b0, 8'($urandom_range(255)));
          push_beat(1'b0, 8'($urandom_range(255)));
        end
      end
      add_random_beats(185);
      wait_drained();
    end

    repeat (8) @(posedge clk_i);
    $display("covered %0d result beats (%0d command bytes, %0d keyframe loads)",
             checked_beats, n_cmd_bytes, n_key_loads);
    $display("over %0d register settings with idle and stall mixes", n_settings);
    if (bad_beats == 0 && servo_out_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d bad beats, %0d beats never seen", bad_beats, servo_out_q.size());
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("timeout with %0d beats still expected", servo_out_q.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
